[rtl/core/hsfd_pkg.sv]
// Shared constants and types for the humidity sensor frame decoder.
package hsfd_pkg;

	// Frame check: CRC-8, polynomial x^8+x^5+x^4+1, zero seed, MSB first
	localparam logic [7:0]  CRC_POLY  = 8'h31;
	localparam logic [7:0]  CRC_INIT  = 8'h00;

	// Raw code layout: bit 1 marks humidity, the two low bits are status
	localparam int          TYPE_BIT  = 1;
	localparam logic [15:0] CODE_MASK = 16'hFFFC;

	// Conversion to hundredths: floor(gain * code / 2^16) - offset
	localparam int          GAIN_W      = 15;
	localparam int          CODE_W      = 16;
	localparam int          PROD_W      = GAIN_W + CODE_W;
	localparam int          SCALE_SHIFT = 16;
	localparam int          VALUE_W     = 15;
	localparam logic [GAIN_W-1:0] T_GAIN  = GAIN_W'(17572);
	localparam logic [GAIN_W-1:0] RH_GAIN = GAIN_W'(12500);
	localparam logic signed [VALUE_W:0] T_OFFSET  = (VALUE_W+1)'(4685);
	localparam logic signed [VALUE_W:0] RH_OFFSET = (VALUE_W+1)'(600);

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_CRC_ERR  = 2'd1,
		ST_TYPE_ERR = 2'd2
	} status_t;

endpackage

[rtl/core/humidity_sensor_frame_decode.sv]
// Sensor frame decoder: CRC check, type check and conversion to hundredths.
// A beat is taken into the input registers, then passes the CRC and multiplier into the result registers.
// Throughput: one beat per cycle; busy is always low, the input and result
// registers form a two-stage pipeline with one multiplier between them.
// Reset clears the stage valid bits, so no done strobe follows reset.
// The receiver cannot stall: done marks each result for exactly one cycle.
module humidity_sensor_frame_decode (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                want_humidity,
	input  logic [7:0]                          data_high,
	input  logic [7:0]                          data_low,
	input  logic [7:0]                          check_byte,
	output logic                                done,
	output hsfd_pkg::status_t                   status,
	output logic signed [hsfd_pkg::VALUE_W-1:0] scaled_value,
	output logic [15:0]                         raw_code
);
	import hsfd_pkg::*;

	logic                      vld_s1;
	logic                      want_s1;
	logic [7:0]                high_s1;
	logic [7:0]                low_s1;
	logic [7:0]                chk_s1;

	logic [7:0]                crc;
	logic [CODE_W-1:0]         code;
	logic signed [VALUE_W-1:0] value;
	status_t                   status_d;
	logic signed [VALUE_W-1:0] value_d;

	logic                      done_s2;
	status_t                   status_s2;
	logic signed [VALUE_W-1:0] value_s2;
	logic [CODE_W-1:0]         code_s2;

	// Never hold off a beat
	assign busy = 1'b0;

	// Input stage: valid bit under reset, payload without reset, loaded on an accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start & ~busy) begin
			want_s1 <= want_humidity;
			high_s1 <= data_high;
			low_s1  <= data_low;
			chk_s1  <= check_byte;
		end
	end

	assign code = {high_s1, low_s1};

	hsfd_crc u_crc (
		.data_high (high_s1),
		.data_low  (low_s1),
		.crc       (crc)
	);

	hsfd_scale u_scale (
		.want_humidity (want_s1),
		.code          (code & CODE_MASK),
		.value         (value)
	);

	// Classify the frame; zero the value on any failed check
	always_comb begin
		if (crc != chk_s1) begin
			status_d = ST_CRC_ERR;
			value_d  = '0;
		end else if (code[TYPE_BIT] != want_s1) begin
			status_d = ST_TYPE_ERR;
			value_d  = '0;
		end else begin
			status_d = ST_OK;
			value_d  = value;
		end
	end

	// Result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			status_s2 <= status_d;
			value_s2  <= value_d;
			code_s2   <= code;
		end
	end

	assign done         = done_s2;
	assign status       = status_s2;
	assign scaled_value = value_s2;
	assign raw_code     = code_s2;

	// Every accepted beat yields a result strobe on done
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("accepted beat produced no result");

	// No result without an accepted beat
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 2))
		else $error("result strobe without an accepted beat");

	// Raw code carries the accepted data bytes
	a_raw_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (raw_code == {$past(data_high, 2), $past(data_low, 2)}))
		else $error("raw code does not match the accepted bytes");

	// Failed checks report a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (scaled_value == '0))
		else $error("nonzero value on a failed frame");

endmodule

[rtl/core/hsfd_crc.sv]
// CRC-8 (poly 0x31) over the two data bytes of one frame.
module hsfd_crc (
	input  logic [7:0] data_high,
	input  logic [7:0] data_low,
	output logic [7:0] crc
);
	import hsfd_pkg::*;

	logic [15:0] msg;
	assign msg = {data_high, data_low};

	// Shift the message through the register, MSB first
	always_comb begin
		logic [7:0] acc;
		logic       fb;
		acc = CRC_INIT;
		for (int i = 15; i >= 0; i--) begin
			fb  = acc[7] ^ msg[i];
			acc = {acc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
		end
		crc = acc;
	end

endmodule

[rtl/core/hsfd_scale.sv]
// Fixed-point conversion of a masked raw code to hundredths.
module hsfd_scale (
	input  logic                                 want_humidity,
	input  logic [hsfd_pkg::CODE_W-1:0]          code,
	output logic signed [hsfd_pkg::VALUE_W-1:0]  value
);
	import hsfd_pkg::*;

	logic [GAIN_W-1:0]          gain;
	logic signed [VALUE_W:0]    offset;
	logic [PROD_W-1:0]          prod;
	logic [VALUE_W-1:0]         quot;
	logic signed [VALUE_W:0]    diff;

	// Pick gain and offset for the requested quantity
	assign gain   = want_humidity ? RH_GAIN : T_GAIN;
	assign offset = want_humidity ? RH_OFFSET : T_OFFSET;

	// Multiply, drop the fraction, remove the offset
	assign prod  = PROD_W'(gain) * PROD_W'(code);
	assign quot  = prod[SCALE_SHIFT +: VALUE_W];
	assign diff  = $signed({1'b0, quot}) - offset;
	assign value = diff[VALUE_W-1:0];

endmodule
